>>> sv/fep_pkg.sv
package fep_pkg;

  // filter geometry
  localparam int TAPS         = 7;
  localparam int HALF         = TAPS / 2;
  localparam int SAMPLE_BITS  = 16;
  localparam int WEIGHT_BITS  = 16;
  localparam int WEIGHT_FRAC  = 15;

  // derived widths
  localparam int PROD_BITS    = SAMPLE_BITS + WEIGHT_BITS;
  localparam int ACC_BITS     = PROD_BITS + $clog2(TAPS);
  localparam int GRP          = 4;
  localparam int NGRP         = (TAPS + GRP - 1) / GRP;
  localparam int IDX_BITS     = $clog2(HALF + 1);
  localparam int SEEN_BITS    = $clog2(2 * HALF + 1);
  localparam int CFG_IDX_BITS = $clog2(TAPS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  // saturation limits and the reset weight of the centre tap
  localparam sample_t SAMPLE_MAX     = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam weight_t WEIGHT_CENTRE  = {1'b0, {(WEIGHT_BITS-1){1'b1}}};

  // results caused by one item: slot 0 is the centre, the rest are flushed
  typedef struct packed {
    logic [HALF:0][SAMPLE_BITS-1:0] vals;
    logic [IDX_BITS-1:0]            count_m1;
    logic                           conv;
    logic                           last;
  } bundle_t;

endpackage

>>> sv/fep_tap_cell.sv
module fep_tap_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  fep_pkg::sample_t sample_in,
  input  logic             weight_we,
  input  fep_pkg::weight_t weight_data,
  input  fep_pkg::weight_t weight_init,
  output fep_pkg::sample_t sample,
  output fep_pkg::prod_t   prod
);
  import fep_pkg::*;

  weight_t weight;

  // tap weight, written through the configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= weight_init;
    end else if (weight_we) begin
      weight <= weight_data;
    end
  end

  // window entry and its weighted product, both taken as the item shifts in
  always_ff @(posedge clk) begin
    if (shift) begin
      sample <= sample_in;
      prod   <= prod_t'(weight) * prod_t'(sample_in);
    end
  end

endmodule

>>> sv/fep_sum_pipe.sv
module fep_sum_pipe (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             emit,
  input  fep_pkg::bundle_t bundle_in,
  input  fep_pkg::prod_t   prods [fep_pkg::TAPS],
  output logic             load_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output fep_pkg::bundle_t out_bundle,
  output fep_pkg::acc_t    out_acc
);
  import fep_pkg::*;

  logic    s1_valid, s2_valid, s3_valid;
  logic    s1_free, s2_free, s3_free;
  bundle_t s1_b, s2_b, s3_b;
  acc_t    grp [NGRP];
  acc_t    grp_next [NGRP];
  acc_t    total, total_next;

  // a stage takes new data when empty or when it moves on this cycle
  assign s3_free    = !s3_valid || out_ready;
  assign s2_free    = !s2_valid || s3_free;
  assign s1_free    = !s1_valid || s2_free;
  assign load_ready = s1_free;

  // group sums of the products held in the cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < TAPS) begin
          grp_next[g] = grp_next[g] + acc_t'(prods[g * GRP + j]);
        end
      end
    end
  end

  // total over the groups
  always_comb begin
    total_next = '0;
    for (int g = 0; g < NGRP; g++) begin
      total_next = total_next + grp[g];
    end
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= load && emit;
      if (s2_free) s2_valid <= s1_valid;
      if (s3_free) s3_valid <= s2_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (s1_free && load) begin
      s1_b <= bundle_in;
    end
    if (s2_free && s1_valid) begin
      s2_b <= s1_b;
      grp  <= grp_next;
    end
    if (s3_free && s2_valid) begin
      s3_b  <= s2_b;
      total <= total_next;
    end
  end

  assign out_valid  = s3_valid;
  assign out_bundle = s3_b;
  assign out_acc    = total;

endmodule

>>> sv/fep_unloader.sv
module fep_unloader (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fep_pkg::bundle_t bundle_in,
  input  fep_pkg::acc_t    acc,
  output logic             out_valid,
  input  logic             out_ready,
  output fep_pkg::sample_t sample_out,
  output logic             was_filtered,
  output logic             last_out
);
  import fep_pkg::*;

  localparam int SH_BITS = ACC_BITS + 1;
  localparam logic signed [SH_BITS-1:0] RND =
    {{(SH_BITS - WEIGHT_FRAC){1'b0}}, 1'b1, {(WEIGHT_FRAC - 1){1'b0}}};

  logic                       full;
  bundle_t                    b, b_next;
  logic [IDX_BITS-1:0]        idx;
  logic                       at_end, take, load;
  logic signed [SH_BITS-1:0]  biased, shifted;
  sample_t                    filt;

  // round half up, then saturate to the sample range
  always_comb begin
    biased  = $signed({acc[ACC_BITS-1], acc}) + RND;
    shifted = biased >>> WEIGHT_FRAC;
    if (shifted > SH_BITS'(SAMPLE_MAX)) begin
      filt = SAMPLE_MAX;
    end else if (shifted < SH_BITS'(SAMPLE_MIN)) begin
      filt = SAMPLE_MIN;
    end else begin
      filt = shifted[SAMPLE_BITS-1:0];
    end
  end

  // centre slot takes the filtered value when convolved
  always_comb begin
    b_next = bundle_in;
    if (bundle_in.conv) begin
      b_next.vals[0] = filt;
    end
  end

  assign at_end   = idx == b.count_m1;
  assign take     = full && out_ready;
  assign in_ready = !full || (out_ready && at_end);
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (take && at_end) begin
      full <= 1'b0;
    end
  end

  // one result per cycle out of the held bundle, while the receiver takes them
  always_ff @(posedge clk) begin
    if (load) begin
      b   <= b_next;
      idx <= '0;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

  assign out_valid    = full;
  assign sample_out   = b.vals[idx];
  assign was_filtered = b.conv && (idx == '0);
  assign last_out     = b.last && at_end;

endmodule

>>> sv/fir_filter_edge_passthrough.sv
// 7-tap FIR filter with edge passthrough, streaming signed 16-bit samples.
// Input channel: in_valid/in_ready with sample_in and last_in. Output
// channel: out_valid/out_ready with sample_out, was_filtered and last_out.
// Tap weights (Q1.15) are written through cfg_we/cfg_index/cfg_data. The
// user must write them only while no item is in flight; the block does not
// enforce this. An index beyond the last tap is ignored. Each result lags
// its item by three samples (the window centre). A sample with last_in set
// also flushes the remaining samples of the signal, so it causes up to four
// results; the last one carries last_out. An item's results pass through
// the product registers in the tap cells, the group sums, the total and the
// output register. Throughput is one item per cycle; an item with last_in
// set holds the output register until each of its results is taken, while
// later items queue in the three sum stages and the input waits only once
// those are full. When the receiver stalls, results wait in the output
// register and the sum stages fill up before in_ready drops.
// Reset clears the sample count, empties every stage and restores the
// weights to a pass filter (centre tap near one, all others zero).
module fir_filter_edge_passthrough (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fep_pkg::sample_t                  sample_in,
  input  logic                              last_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fep_pkg::sample_t                  sample_out,
  output logic                              was_filtered,
  output logic                              last_out,
  input  logic                              cfg_we,
  input  logic [fep_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fep_pkg::WEIGHT_BITS-1:0]   cfg_data
);
  import fep_pkg::*;

  logic [SEEN_BITS-1:0] samples_seen, samples_seen_next;
  logic                 accept, ge_half, ge_full, emit, pipe_ready, pipe_valid;
  logic                 unl_ready;
  logic [IDX_BITS-1:0]  top_sel;
  sample_t              nw  [TAPS];
  sample_t              win [TAPS];
  prod_t                prods [TAPS];
  bundle_t              bundle, pipe_bundle;
  acc_t                 pipe_acc;

  assign accept   = in_valid && in_ready;
  assign in_ready = pipe_ready;

  // row of tap cells: the first takes the new sample and each other its neighbour's as an item shifts in
  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    localparam weight_t INIT = (k == HALF) ? WEIGHT_CENTRE : '0;
    if (k == 0) begin : g_head
      assign nw[k] = sample_in;
    end else begin : g_body
      assign nw[k] = win[k-1];
    end
    fep_tap_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift       (accept),
      .sample_in   (nw[k]),
      .weight_we   (cfg_we && (cfg_index == CFG_IDX_BITS'(k))),
      .weight_data (cfg_data),
      .weight_init (INIT),
      .sample      (win[k]),
      .prod        (prods[k])
    );
  end

  // position in the signal decides what the item emits
  assign ge_half = samples_seen >= SEEN_BITS'(HALF);
  assign ge_full = samples_seen >= SEEN_BITS'(2 * HALF);
  assign emit    = last_in || ge_half;
  assign top_sel = ge_half ? IDX_BITS'(HALF) : samples_seen[IDX_BITS-1:0];

  // results of the item: slot j holds the sample top_sel - j steps old
  always_comb begin
    bundle          = '0;
    bundle.conv     = ge_full;
    bundle.last     = last_in;
    bundle.count_m1 = last_in ? top_sel : '0;
    for (int j = 0; j <= HALF; j++) begin
      for (int t = 0; t <= HALF; t++) begin
        if (top_sel == IDX_BITS'(t) && j <= t) begin
          bundle.vals[j] = nw[(t >= j) ? (t - j) : 0];
        end
      end
    end
  end

  // sample count, saturating once the window is full and cleared by an item with last_in set
  always_comb begin
    samples_seen_next = samples_seen;
    if (last_in) begin
      samples_seen_next = '0;
    end else if (!ge_full) begin
      samples_seen_next = samples_seen + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
    end else if (accept) begin
      samples_seen <= samples_seen_next;
    end
  end

  fep_sum_pipe u_sum (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .emit       (emit),
    .bundle_in  (bundle),
    .prods      (prods),
    .load_ready (pipe_ready),
    .out_valid  (pipe_valid),
    .out_ready  (unl_ready),
    .out_bundle (pipe_bundle),
    .out_acc    (pipe_acc)
  );

  fep_unloader u_unl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (pipe_valid),
    .in_ready     (unl_ready),
    .bundle_in    (pipe_bundle),
    .acc          (pipe_acc),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_out   (sample_out),
    .was_filtered (was_filtered),
    .last_out     (last_out)
  );

endmodule

>>> sv/fep_checker.sv
module fep_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input fep_pkg::sample_t sample_out,
  input logic             was_filtered,
  input logic             last_out
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out)
      && $stable(was_filtered) && $stable(last_out))
    else $error("stalled result changed");

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // after reset every stage is empty, so an item can enter
  a_rst_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

  // the final result of a signal is always an edge sample
  a_last_edge: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_out |-> !was_filtered)
    else $error("filtered sample flagged as last");

  // an offered item with nothing in flight downstream is taken
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid && $past(!out_valid) && $past(!out_valid, 2)
      && $past(!out_valid, 3) && $past(!in_valid) && $past(!in_valid, 2)
      && $past(!in_valid, 3) |-> in_ready)
    else $error("idle block refused an item");

endmodule

bind fir_filter_edge_passthrough fep_checker u_fep_checker (.*);
